/* src/hilbert_index_to_point_assert.svh */
// ---------------------------------------------------------------------------
// hilbert_index_to_point assertion macros
// concurrent assertion wrappers used by the checker file h2p_checker
// ---------------------------------------------------------------------------
`ifndef HILBERT_INDEX_TO_POINT_ASSERT_SVH
`define HILBERT_INDEX_TO_POINT_ASSERT_SVH

// checked only while out of reset
`define H2P_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define H2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/h2p_pkg.sv */
// ---------------------------------------------------------------------------
// h2p_pkg
// shared widths and constants of the curve position to point mapper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package h2p_pkg;

    localparam int POS_W   = 64;  // curve position width
    localparam int COORD_W = 17;  // signed coordinate width
    localparam int DIM_W   = 4;   // axis number width
    localparam int CFG_W   = 5;   // levels register width
    localparam int LV_W    = 6;   // clamped level count, holds up to 63

    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd10;
    localparam logic [LV_W-1:0]  LEVELS_MIN   = 6'd2;

endpackage

`default_nettype wire

/* src/h2p_stage.sv */
// ---------------------------------------------------------------------------
// h2p_stage
// one refinement level: node lookup, axis swap, orientation fold, accumulate
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2p_stage #(
    parameter int DIMS   = 4,
    parameter int LEVEL  = 0,
    parameter int AXIS_W = $clog2(DIMS)
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic [h2p_pkg::LV_W-1:0]                   i_levels,
    input  wire logic                                       i_valid,
    output logic                                            o_ready,
    input  wire logic [h2p_pkg::POS_W-1:0]                  i_position,
    input  wire logic                                       i_at_end,
    input  wire logic [AXIS_W-1:0]                          i_carried,
    input  wire logic [DIMS-1:0]                            i_orient,
    input  wire logic [DIMS-1:0][h2p_pkg::COORD_W-1:0]      i_acc,
    output logic                                            o_valid,
    input  wire logic                                       i_ready,
    output logic [h2p_pkg::POS_W-1:0]                       o_position,
    output logic                                            o_at_end,
    output logic [AXIS_W-1:0]                               o_carried,
    output logic [DIMS-1:0]                                 o_orient,
    output logic [DIMS-1:0][h2p_pkg::COORD_W-1:0]           o_acc
);

    localparam int POS_W   = h2p_pkg::POS_W;
    localparam int COORD_W = h2p_pkg::COORD_W;
    localparam int LV_W    = h2p_pkg::LV_W;

    // signs are kept as negative flags: 1 means -1
    logic [DIMS-1:0]              w_grp;
    logic [DIMS-1:0]              w_low;
    logic [DIMS-1:0]              w_uneg;
    logic [DIMS-1:0]              w_vneg;
    logic [DIMS-1:0]              w_sneg;
    logic [DIMS-1:0]              w_orient;
    logic [AXIS_W-1:0]            w_axis;
    logic [AXIS_W-1:0]            w_car;
    logic                         w_fold;
    logic                         w_pn;
    logic                         w_cn;
    logic                         w_t;
    logic                         w_active;
    logic [DIMS-1:0][COORD_W-1:0] w_acc;

    logic                         r_valid;
    logic [POS_W-1:0]             r_pos;
    logic                         r_end;
    logic [AXIS_W-1:0]            r_car;
    logic [DIMS-1:0]              r_orient;
    logic [DIMS-1:0][COORD_W-1:0] r_acc;

    assign w_active = (i_levels > LV_W'(LEVEL));
    assign o_ready  = !r_valid || i_ready;

    always_comb begin
        int p;
        // group of this level, missing low bits read as zero
        w_grp = '0;
        for (int b = 0; b < DIMS; b++) begin
            p = LEVEL * DIMS + b;
            if (p < POS_W) begin
                w_grp[DIMS-1-b] = i_position[POS_W-1-p];
            end
        end
        if (i_at_end) begin
            w_grp = '1;
        end

        // node sign vector and exit axis
        w_axis = '0;
        w_fold = 1'b0;
        w_pn   = 1'b1;
        w_uneg = '0;
        for (int i = 0; i < DIMS; i++) begin
            w_cn  = !w_grp[DIMS-1-i];
            w_low = w_grp & ((DIMS'(1) << (DIMS-1-i)) - DIMS'(1));
            if (w_grp[DIMS-1-i]) begin
                if ((w_low == '0) && (i != DIMS-1)) begin
                    w_axis = AXIS_W'(i);
                    w_fold = 1'b1;
                end
            end else begin
                if ((w_low == ((DIMS'(1) << (DIMS-1-i)) - DIMS'(1))) && (i != DIMS-1)) begin
                    w_axis = AXIS_W'(i);
                    w_fold = 1'b0;
                end
            end
            w_uneg[i] = !(w_pn ^ w_cn);
            w_pn      = w_cn;
        end
        w_vneg         = w_uneg;
        w_vneg[w_axis] = w_vneg[w_axis] ^ w_fold;
        w_vneg[DIMS-1] = !w_vneg[DIMS-1];

        // curve start and curve end corners
        if (w_grp == '0) begin
            w_axis = AXIS_W'(DIMS-1);
            w_uneg = '1;
            w_vneg = '1;
        end else if (w_grp == '1) begin
            w_axis         = AXIS_W'(DIMS-1);
            w_uneg         = '1;
            w_uneg[0]      = 1'b0;
            w_vneg         = '1;
            w_vneg[0]      = 1'b0;
            w_vneg[DIMS-1] = 1'b0;
        end

        // permute by the carried axis
        w_t               = w_uneg[0];
        w_uneg[0]         = w_uneg[i_carried];
        w_uneg[i_carried] = w_t;
        w_t               = w_vneg[0];
        w_vneg[0]         = w_vneg[i_carried];
        w_vneg[i_carried] = w_t;

        if (w_axis == '0) begin
            w_car = i_carried;
        end else if (w_axis == i_carried) begin
            w_car = '0;
        end else begin
            w_car = w_axis;
        end

        // horner step: acc = 2 acc + s
        for (int i = 0; i < DIMS; i++) begin
            w_sneg[i]   = w_uneg[i] ^ i_orient[i];
            w_orient[i] = i_orient[i] ^ !w_vneg[i];
            w_acc[i]    = (i_acc[i] << 1) + (w_sneg[i] ? {COORD_W{1'b1}} : COORD_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pos <= i_position;
            r_end <= i_at_end;
            if (w_active) begin
                r_car    <= w_car;
                r_orient <= w_orient;
                r_acc    <= w_acc;
            end else begin
                r_car    <= i_carried;
                r_orient <= i_orient;
                r_acc    <= i_acc;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_position = r_pos;
    assign o_at_end   = r_end;
    assign o_carried  = r_car;
    assign o_orient   = r_orient;
    assign o_acc      = r_acc;

endmodule

`default_nettype wire

/* src/h2p_serial.sv */
// ---------------------------------------------------------------------------
// h2p_serial
// holds one finished point and hands out its coordinates one word at a time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2p_serial #(
    parameter int DIMS  = 4,
    parameter int CNT_W = $clog2(DIMS)
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [DIMS-1:0][h2p_pkg::COORD_W-1:0]  i_acc,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [h2p_pkg::DIM_W-1:0]                   o_dim_index,
    output logic signed [h2p_pkg::COORD_W-1:0]          o_coord,
    output logic                                        o_last
);

    localparam int COORD_W = h2p_pkg::COORD_W;
    localparam int DIM_W   = h2p_pkg::DIM_W;

    logic                         r_valid;
    logic [CNT_W-1:0]             r_cnt;
    logic [DIMS-1:0][COORD_W-1:0] r_acc;
    logic                         w_last;

    assign w_last  = (r_cnt == CNT_W'(DIMS-1));
    assign o_ready = !r_valid || (i_ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_cnt   <= '0;
        end else if (i_ready) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_acc <= i_acc;
        end
    end

    assign o_valid     = r_valid;
    assign o_dim_index = DIM_W'(r_cnt);
    assign o_coord     = $signed(r_acc[r_cnt]);
    assign o_last      = w_last;

endmodule

`default_nettype wire

/* src/hilbert_index_to_point.sv */
// path: an accepted point passes the MAX_LEVELS stage registers and the
//   serialiser register; its coordinate words then follow one per cycle
//   while the output is not stalled
// flow: the serialiser takes the next point as the last of DIMS words goes;
//   the level pipeline takes a new point in every cycle unless stalled
// reset: synchronous active low, clears all valid flags and sets levels to 10
// ---------------------------------------------------------------------------
// hilbert_index_to_point
// maps a curve position to a DIMS-dimensional point, one coordinate per word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hilbert_index_to_point #(
    parameter int DIMS       = 4,
    parameter int MAX_LEVELS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // levels register
    input  wire logic                               i_cfg_we,
    input  wire logic [h2p_pkg::CFG_W-1:0]          i_cfg_data,
    // input words
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [h2p_pkg::POS_W-1:0]          i_position,
    input  wire logic                               i_at_end,
    // output words
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [h2p_pkg::DIM_W-1:0]               o_dim_index,
    output logic signed [h2p_pkg::COORD_W-1:0]      o_coord,
    output logic                                    o_last
);

    localparam int POS_W   = h2p_pkg::POS_W;
    localparam int COORD_W = h2p_pkg::COORD_W;
    localparam int CFG_W   = h2p_pkg::CFG_W;
    localparam int LV_W    = h2p_pkg::LV_W;
    localparam int AXIS_W  = $clog2(DIMS);

    // levels register, clamped to the supported range on use
    logic [CFG_W-1:0] r_levels;
    logic [LV_W-1:0]  w_levels_ext;
    logic [LV_W-1:0]  w_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= h2p_pkg::LEVELS_RESET;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_data;
        end
    end

    assign w_levels_ext = LV_W'(r_levels);

    always_comb begin
        if (w_levels_ext < h2p_pkg::LEVELS_MIN) begin
            w_levels = h2p_pkg::LEVELS_MIN;
        end else if (w_levels_ext > LV_W'(MAX_LEVELS)) begin
            w_levels = LV_W'(MAX_LEVELS);
        end else begin
            w_levels = w_levels_ext;
        end
    end

    // stage chain, slot j feeds the stage for level j
    // each level is a Horner step acc = 2 acc +/- 1, so levels past the
    // configured count simply pass the word through unchanged
    logic [MAX_LEVELS:0]                          s_valid;
    logic [MAX_LEVELS:0]                          s_ready;
    logic [MAX_LEVELS:0][POS_W-1:0]               s_pos;
    logic [MAX_LEVELS:0]                          s_end;
    logic [MAX_LEVELS:0][AXIS_W-1:0]              s_car;
    logic [MAX_LEVELS:0][DIMS-1:0]                s_orient;
    logic [MAX_LEVELS:0][DIMS-1:0][COORD_W-1:0]   s_acc;

    // entry: no carried axis, all orientations positive, sums empty
    assign s_valid[0]  = i_valid;
    assign o_ready     = s_ready[0];
    assign s_pos[0]    = i_position;
    assign s_end[0]    = i_at_end;
    assign s_car[0]    = '0;
    assign s_orient[0] = '0;
    assign s_acc[0]    = '0;

    for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_level
        h2p_stage #(
            .DIMS   (DIMS),
            .LEVEL  (j),
            .AXIS_W (AXIS_W)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_levels   (w_levels),
            .i_valid    (s_valid[j]),
            .o_ready    (s_ready[j]),
            .i_position (s_pos[j]),
            .i_at_end   (s_end[j]),
            .i_carried  (s_car[j]),
            .i_orient   (s_orient[j]),
            .i_acc      (s_acc[j]),
            .o_valid    (s_valid[j+1]),
            .i_ready    (s_ready[j+1]),
            .o_position (s_pos[j+1]),
            .o_at_end   (s_end[j+1]),
            .o_carried  (s_car[j+1]),
            .o_orient   (s_orient[j+1]),
            .o_acc      (s_acc[j+1])
        );
    end

    // output register: one finished point, served as DIMS words
    h2p_serial #(
        .DIMS (DIMS)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid[MAX_LEVELS]),
        .o_ready     (s_ready[MAX_LEVELS]),
        .i_acc       (s_acc[MAX_LEVELS]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_dim_index (o_dim_index),
        .o_coord     (o_coord),
        .o_last      (o_last)
    );

    // position, end flag, axis and orientation are spent after the final level
    logic w_tail_unused;
    assign w_tail_unused = ^{s_pos[MAX_LEVELS], s_end[MAX_LEVELS],
                             s_car[MAX_LEVELS], s_orient[MAX_LEVELS]};

endmodule

`default_nettype wire

/* src/h2p_checker.sv */
// ---------------------------------------------------------------------------
// h2p_checker
// port level checks on the output word stream of the point mapper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2p_checker #(
    parameter int DIMS = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [h2p_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic                               o_ready,
    input  wire logic [h2p_pkg::POS_W-1:0]          i_position,
    input  wire logic                               i_at_end,
    input  wire logic                               o_valid,
    input  wire logic                               i_ready,
    input  wire logic [h2p_pkg::DIM_W-1:0]          o_dim_index,
    input  wire logic signed [h2p_pkg::COORD_W-1:0] o_coord,
    input  wire logic                               o_last
);

`include "hilbert_index_to_point_assert.svh"

    localparam int DIM_W = h2p_pkg::DIM_W;

    // a stalled output word stays put
    `H2P_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_dim_index) && $stable(o_coord), "output word changed while stalled")

    // last flag marks the top axis only
    `H2P_ASSERT(a_last_axis, i_clk, i_rst_n, o_valid |-> (o_last == (o_dim_index == DIM_W'(DIMS-1))), "last flag does not match axis")

    // the rest of a point follows at once, axis by axis
    `H2P_ASSERT(a_axis_seq, i_clk, i_rst_n, o_valid && i_ready && !o_last |=> o_valid && (o_dim_index == $past(o_dim_index) + DIM_W'(1)), "axis sequence broken")

    // every coordinate is an odd multiple of the finest step
    `H2P_ASSERT(a_coord_odd, i_clk, i_rst_n, o_valid |-> o_coord[0], "coordinate is even")

    // reset empties the output
    `H2P_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    logic w_unused;
    assign w_unused = ^{i_cfg_we, i_cfg_data, i_valid, o_ready, i_position, i_at_end};

endmodule

bind hilbert_index_to_point h2p_checker #(.DIMS(DIMS)) u_h2p_checker (.*);

`default_nettype wire

/* verif/h2p_point_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// h2p_point_checker
// watches the position and coordinate channels of the curve position to
// point mapper, predicts the coordinate words of every accepted position
// and compares them in order with the words that come out
// ---------------------------------------------------------------------------

module h2p_point_checker #(
    parameter int DIMS       = 4,
    parameter int MAX_LEVELS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [h2p_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_pt_valid,
    input  logic                                i_pt_ready,
    input  logic [h2p_pkg::POS_W-1:0]           i_position,
    input  logic                                i_at_end,
    input  logic                                i_cw_valid,
    input  logic                                i_cw_ready,
    input  logic [h2p_pkg::DIM_W-1:0]           i_dim_index,
    input  logic signed [h2p_pkg::COORD_W-1:0]  i_coord,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_words_pending
);
    localparam int POS_W   = h2p_pkg::POS_W;
    localparam int COORD_W = h2p_pkg::COORD_W;
    localparam int DIM_W   = h2p_pkg::DIM_W;
    localparam int CFG_W   = h2p_pkg::CFG_W;

    typedef struct packed {
        logic [DIM_W-1:0]          dim;
        logic signed [COORD_W-1:0] coord;
        logic                      last;
    } t_coord_word;

    t_coord_word        coord_words_due [$];
    logic [CFG_W-1:0]   levels_reg;
    int                 fail_count;

    // DIMS bits of one level, most significant group first, zero past bit 64
    function automatic int level_group(input logic [POS_W-1:0] pos, input int lev);
        int grp;
        int p;
        grp = 0;
        for (int b = 0; b < DIMS; b++) begin
            p = lev * DIMS + b;
            grp = (grp << 1) | ((p < POS_W) ? int'(pos[POS_W-1-p]) : 0);
        end
        return grp;
    endfunction

    // cube node of a group: entry signs, exit signs and exit axis
    function automatic void node_signs(input int grp, output int u [DIMS],
                                       output int v [DIMS], output int axis);
        int rest;
        int prev;
        int fold;
        int half;
        int cur;
        axis = 0;
        for (int i = 0; i < DIMS; i++) begin
            u[i] = -1;
            v[i] = -1;
        end
        if (grp == 0) begin
            axis = DIMS - 1;
        end else if (grp == (1 << DIMS) - 1) begin
            axis = DIMS - 1;
            u[0] = 1;
            v[0] = 1;
            v[DIMS-1] = 1;
        end else begin
            rest = grp;
            prev = -1;
            fold = 1;
            for (int i = 0; i < DIMS; i++) begin
                half = 1 << (DIMS - 1 - i);
                if (rest >= half) begin
                    if (rest == half && rest != 1) begin
                        axis = i;
                        fold = -1;
                    end
                    rest -= half;
                    cur = 1;
                end else begin
                    cur = -1;
                    if (rest == half - 1 && rest != 0) begin
                        axis = i;
                        fold = 1;
                    end
                end
                u[i] = -prev * cur;
                v[i] = u[i];
                prev = cur;
            end
            v[axis] *= fold;
            v[DIMS-1] = -v[DIMS-1];
        end
    endfunction

    // walk the levels, accumulating weighted signs per axis
    function automatic void predict_point(input logic [POS_W-1:0] pos, input logic at_end,
                                          input logic [CFG_W-1:0] lv_reg,
                                          output int acc [DIMS]);
        int lv;
        int orient [DIMS];
        int u [DIMS];
        int v [DIMS];
        int axis;
        int carried;
        int grp;
        int tmp;
        lv = int'(lv_reg);
        if (lv < int'(h2p_pkg::LEVELS_MIN)) lv = int'(h2p_pkg::LEVELS_MIN);
        if (lv > MAX_LEVELS) lv = MAX_LEVELS;
        carried = 0;
        for (int i = 0; i < DIMS; i++) begin
            acc[i] = 0;
            orient[i] = 1;
        end
        for (int j = 0; j < lv; j++) begin
            grp = at_end ? (1 << DIMS) - 1 : level_group(pos, j);
            node_signs(grp, u, v, axis);
            tmp = u[0]; u[0] = u[carried]; u[carried] = tmp;
            tmp = v[0]; v[0] = v[carried]; v[carried] = tmp;
            if (axis == 0)
                axis = carried;
            else if (axis == carried)
                axis = 0;
            carried = axis;
            for (int i = 0; i < DIMS; i++) begin
                acc[i] += u[i] * orient[i] * (1 << (lv - 1 - j));
                orient[i] *= -v[i];
            end
        end
    endfunction

    always @(posedge i_clk) begin
        int          acc [DIMS];
        t_coord_word w;
        t_coord_word got;
        if (!i_rst_n) begin
            levels_reg = h2p_pkg::LEVELS_RESET;
            coord_words_due.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we)
                levels_reg = i_cfg_data;
            // outgoing word first, a new point cannot answer in the same cycle
            if (i_cw_valid && i_cw_ready) begin
                got = '{dim: i_dim_index, coord: i_coord, last: i_last};
                if (coord_words_due.size() == 0) begin
                    $error("coord word for axis %0d with no point pending", i_dim_index);
                    fail_count++;
                end else begin
                    w = coord_words_due.pop_front();
                    if (got.dim !== w.dim) begin
                        $error("dim_index: expected %0d, got %0d", w.dim, got.dim);
                        fail_count++;
                    end
                    if (got.coord !== w.coord) begin
                        $error("coord: expected %0d, got %0d", w.coord, got.coord);
                        fail_count++;
                    end
                    if (got.last !== w.last) begin
                        $error("last: expected %0d, got %0d", w.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (i_pt_valid && i_pt_ready) begin
                predict_point(i_position, i_at_end, levels_reg, acc);
                for (int i = 0; i < DIMS; i++) begin
                    w.dim   = DIM_W'(i);
                    w.coord = acc[i][COORD_W-1:0];
                    w.last  = (i == DIMS - 1);
                    coord_words_due.push_back(w);
                end
            end
        end
        o_fail_count    <= fail_count;
        o_words_pending <= coord_words_due.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the curve position to point mapper: directed
// corner positions, then random positions across several levels settings,
// with random gaps on the position side and stalls on the coordinate side
// ---------------------------------------------------------------------------

module tb_top;
    localparam int POS_W      = h2p_pkg::POS_W;
    localparam int COORD_W    = h2p_pkg::COORD_W;
    localparam int DIM_W      = h2p_pkg::DIM_W;
    localparam int CFG_W      = h2p_pkg::CFG_W;

    localparam int DIMS       = 4;
    localparam int MAX_LEVELS = 16;
    // pipeline depth plus the serialiser, with some margin
    localparam int SETTLE     = MAX_LEVELS + DIMS + 8;
    // cycles without any accepted word before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_PTS  = 14;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       pt_valid = 1'b0;
    logic                       pt_ready;
    logic [POS_W-1:0]           position = '0;
    logic                       at_end = 1'b0;
    logic                       cw_valid;
    logic                       cw_ready = 1'b0;
    logic [DIM_W-1:0]           dim_index;
    logic signed [COORD_W-1:0]  coord;
    logic                       last;

    int   fail_count;
    int   words_pending;
    int   idle_cycles = 0;
    int   stall_left = 0;
    logic tx_gaps_on = 1'b1;
    logic rx_stalls_on = 1'b1;

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hilbert_index_to_point #(
        .DIMS       (DIMS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_valid     (pt_valid),
        .o_ready     (pt_ready),
        .i_position  (position),
        .i_at_end    (at_end),
        .o_valid     (cw_valid),
        .i_ready     (cw_ready),
        .o_dim_index (dim_index),
        .o_coord     (coord),
        .o_last      (last)
    );

    h2p_point_checker #(
        .DIMS       (DIMS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_pt_valid      (pt_valid),
        .i_pt_ready      (pt_ready),
        .i_position      (position),
        .i_at_end        (at_end),
        .i_cw_valid      (cw_valid),
        .i_cw_ready      (cw_ready),
        .i_dim_index     (dim_index),
        .i_coord         (coord),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // idle length: usually small, none included, and one draw in ten a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 2);
    endfunction

    // random position, often with whole groups forced to the all-zero or
    // all-ones nodes so the special node shapes turn up deep in the curve
    function automatic logic [POS_W-1:0] rand_position();
        logic [POS_W-1:0] p;
        p = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0) begin
            for (int g = 0; g < POS_W / DIMS; g++) begin
                case ($urandom_range(0, 3))
                    0: p[POS_W-1-g*DIMS -: DIMS] = '0;
                    1: p[POS_W-1-g*DIMS -: DIMS] = '1;
                    default: ;
                endcase
            end
        end
        return p;
    endfunction

    // coordinate side back-pressure
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            cw_ready   <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            cw_ready   <= 1'b0;
        end else begin
            cw_ready <= 1'b1;
        end
    end

    // watchdog: any accepted word on either side restarts the count
    always @(posedge clk) begin
        if ((pt_valid && pt_ready) || (cw_valid && cw_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // one position word, with an optional gap in front of it
    task automatic send_point(input logic [POS_W-1:0] pos, input logic end_flag);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_valid <= 1'b1;
        position <= pos;
        at_end   <= end_flag;
        do @(posedge clk); while (!pt_ready);
    endtask

    // hold off until every coordinate word is back and the pipe is empty
    task automatic drain();
        pt_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] lv);
        cfg_we   <= 1'b1;
        cfg_data <= lv;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [POS_W-1:0] corner_pos [11];
        logic [CFG_W-1:0] levels_plan [7];

        corner_pos = '{
            64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
            64'h1111_1111_1111_1111, 64'hEEEE_EEEE_EEEE_EEEE,
            64'h0000_0000_0000_0001
        };
        // bounds of the supported range, out-of-range values that get clamped,
        // and one ordinary setting
        levels_plan = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17,
                        CFG_W'($urandom_range(3, 15))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at the reset density, then the curve end point
        foreach (corner_pos[k])
            send_point(corner_pos[k], 1'b0);
        send_point('0, 1'b1);
        send_point({$urandom, $urandom}, 1'b1);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_levels(levels_plan[ph]);
            // some phases run without gaps on one side or the other
            tx_gaps_on   <= (ph % 3 != 1);
            rx_stalls_on <= (ph % 3 != 2);
            for (int n = 0; n < PHASE_PTS; n++)
                send_point(rand_position(), $urandom_range(0, 9) == 0);
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
